>>> hdl/frame_length_by_mode_assert.svh
// assertion macros for the frame length block
// both expect clk and rst_n in the including scope
`ifndef FRAME_LENGTH_BY_MODE_ASSERT_SVH
`define FRAME_LENGTH_BY_MODE_ASSERT_SVH

// same-cycle implication
`define FLBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame_length_by_mode: same-cycle check failed");

// next-cycle implication
`define FLBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame_length_by_mode: next-cycle check failed");

`endif

>>> hdl/flbm_pkg.sv
`default_nettype none

package flbm_pkg;

  localparam int INDEX_WIDTH    = 31;
  localparam int LEN_WIDTH      = 16;
  localparam int DIV_WIDTH      = LEN_WIDTH + 1;
  localparam int MODE_WIDTH     = 3;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int FIFO_DEPTH     = 2;
  localparam int PIPE_DEPTH     = INDEX_WIDTH;
  localparam int IMIX_SEL_WIDTH = 4;

  // length modes
  localparam logic [MODE_WIDTH-1:0] MODE_FIXED  = 3'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_INC    = 3'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_DEC    = 3'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_RANDOM = 3'd3;
  localparam logic [MODE_WIDTH-1:0] MODE_IMIX   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LENGTH_MODE  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIXED_LENGTH = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_LENGTH   = 2'd3;

  // reset values and lengths
  localparam logic [LEN_WIDTH-1:0]  LEN_DEFAULT     = 16'd64;
  localparam logic [LEN_WIDTH-1:0]  LEN_IMIX_MID    = 16'd594;
  localparam logic [LEN_WIDTH-1:0]  LEN_IMIX_BIG    = 16'd1518;
  localparam logic [MODE_WIDTH-1:0] RST_LENGTH_MODE = MODE_FIXED;
  localparam logic [LEN_WIDTH-1:0]  RST_FIXED       = LEN_DEFAULT;
  localparam logic [LEN_WIDTH-1:0]  RST_MIN         = LEN_DEFAULT;
  localparam logic [LEN_WIDTH-1:0]  RST_MAX         = LEN_IMIX_BIG;
  localparam logic [DIV_WIDTH-1:0]  IMIX_PERIOD     = 17'd12;

  // what the back end must do with a word
  typedef enum logic [2:0] {
    CLS_FIXED,
    CLS_INC,
    CLS_DEC,
    CLS_IMIX,
    CLS_RANGE_ERR,
    CLS_DEFAULT
  } cls_t;

  typedef struct packed {
    logic [MODE_WIDTH-1:0] length_mode;
    logic [LEN_WIDTH-1:0]  fixed_length;
    logic [LEN_WIDTH-1:0]  min_length;
    logic [LEN_WIDTH-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    cls_t                   cls;
    logic [DIV_WIDTH-1:0]   divisor;
    logic [INDEX_WIDTH-1:0] index;
  } item_t;

  // one restoring remainder step; rem < div on entry and on exit
  function automatic logic [DIV_WIDTH-1:0] rem_step(
    input logic [DIV_WIDTH-1:0] rem,
    input logic                 dbit,
    input logic [DIV_WIDTH-1:0] div
  );
    logic [DIV_WIDTH:0] tmp;
    logic [DIV_WIDTH:0] diff;
    tmp  = {rem, dbit};
    diff = tmp - {1'b0, div};
    if (tmp >= {1'b0, div}) begin
      return diff[DIV_WIDTH-1:0];
    end else begin
      return tmp[DIV_WIDTH-1:0];
    end
  endfunction

  // imix pattern, 64/594/1518 in 7:4:1
  function automatic logic [LEN_WIDTH-1:0] imix_len(input logic [IMIX_SEL_WIDTH-1:0] sel);
    case (sel)
      4'd1, 4'd3, 4'd8, 4'd10: return LEN_IMIX_MID;
      4'd5:                    return LEN_IMIX_BIG;
      default:                 return LEN_DEFAULT;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> hdl/flbm_front.sv
`default_nettype none

module flbm_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire flbm_pkg::cfg_t                  cfg,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [flbm_pkg::INDEX_WIDTH-1:0] in_frame_index,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output flbm_pkg::item_t                      push_item
);
  import flbm_pkg::*;

  item_t                 cls_item;
  logic [DIV_WIDTH-1:0]  span;
  logic                  hold_valid_r;
  logic                  hold_valid_nxt;
  item_t                 hold_item_r;

  // span of the length range, one wider than a length
  assign span = {1'b0, cfg.max_length} - {1'b0, cfg.min_length} + DIV_WIDTH'(1);

  // classify the incoming word
  always_comb begin
    cls_item.index   = in_frame_index;
    cls_item.divisor = IMIX_PERIOD;
    cls_item.cls     = CLS_DEFAULT;
    case (cfg.length_mode)
      MODE_FIXED: begin
        cls_item.cls = CLS_FIXED;
      end
      MODE_INC, MODE_DEC: begin
        if (cfg.max_length < cfg.min_length) begin
          cls_item.cls = CLS_RANGE_ERR;
        end else begin
          cls_item.cls     = (cfg.length_mode == MODE_INC) ? CLS_INC : CLS_DEC;
          cls_item.divisor = span;
        end
      end
      MODE_IMIX: begin
        cls_item.cls = CLS_IMIX;
      end
      default: begin
        cls_item.cls = CLS_DEFAULT;
      end
    endcase
  end

  // holding stage, free when empty or draining into the queue
  assign in_stall       = hold_valid_r && !push_ready;
  assign hold_valid_nxt = in_stall ? hold_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_item_r <= cls_item;
    end
  end

  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

endmodule

`default_nettype wire

>>> hdl/flbm_fifo.sv
`default_nettype none

module flbm_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire flbm_pkg::item_t  push_item,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output flbm_pkg::item_t       pop_item
);
  import flbm_pkg::*;

  localparam int PTR_WIDTH = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

  item_t                mem_r [FIFO_DEPTH];
  logic [PTR_WIDTH-1:0] wr_ptr_r;
  logic [PTR_WIDTH-1:0] wr_ptr_nxt;
  logic [PTR_WIDTH-1:0] rd_ptr_r;
  logic [PTR_WIDTH-1:0] rd_ptr_nxt;
  logic [CNT_WIDTH-1:0] count_r;
  logic [CNT_WIDTH-1:0] count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count_r != CNT_WIDTH'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_WIDTH'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_WIDTH'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_WIDTH'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> hdl/flbm_back.sv
`default_nettype none

module flbm_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire flbm_pkg::cfg_t              cfg,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire flbm_pkg::item_t             pop_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [flbm_pkg::LEN_WIDTH-1:0]   out_frame_length,
  output logic                             out_range_error
);
  import flbm_pkg::*;

  localparam int LAST = PIPE_DEPTH - 1;

  logic                   st_valid_r  [PIPE_DEPTH];
  logic                   st_valid_nxt[PIPE_DEPTH];
  logic [DIV_WIDTH-1:0]   st_rem_r    [PIPE_DEPTH];
  logic [DIV_WIDTH-1:0]   st_rem_nxt  [PIPE_DEPTH];
  logic [DIV_WIDTH-1:0]   st_div_r    [PIPE_DEPTH];
  logic [DIV_WIDTH-1:0]   st_div_nxt  [PIPE_DEPTH];
  logic [INDEX_WIDTH-1:0] st_idx_r    [PIPE_DEPTH];
  logic [INDEX_WIDTH-1:0] st_idx_nxt  [PIPE_DEPTH];
  cls_t                   st_cls_r    [PIPE_DEPTH];
  cls_t                   st_cls_nxt  [PIPE_DEPTH];

  logic                   pipe_en;
  logic [LEN_WIDTH-1:0]   off;
  logic [LEN_WIDTH-1:0]   len_nxt;
  logic                   err_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [LEN_WIDTH-1:0]   out_len_r;
  logic                   out_err_r;

  // whole pipeline moves when the output register can take a word
  assign pipe_en   = !out_valid_r || !out_stall;
  assign pop_ready = pipe_en;

  // remainder pipeline, one dividend bit per stage, msb first
  always_comb begin
    st_valid_nxt[0] = pop_valid;
    st_rem_nxt[0]   = rem_step('0, pop_item.index[INDEX_WIDTH-1], pop_item.divisor);
    st_div_nxt[0]   = pop_item.divisor;
    st_idx_nxt[0]   = pop_item.index;
    st_cls_nxt[0]   = pop_item.cls;
    for (int s = 1; s < PIPE_DEPTH; s++) begin
      st_valid_nxt[s] = st_valid_r[s-1];
      st_rem_nxt[s]   = rem_step(st_rem_r[s-1], st_idx_r[s-1][INDEX_WIDTH-1-s],
                                 st_div_r[s-1]);
      st_div_nxt[s]   = st_div_r[s-1];
      st_idx_nxt[s]   = st_idx_r[s-1];
      st_cls_nxt[s]   = st_cls_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PIPE_DEPTH; s++) begin
        st_valid_r[s] <= 1'b0;
      end
    end else if (pipe_en) begin
      for (int s = 0; s < PIPE_DEPTH; s++) begin
        st_valid_r[s] <= st_valid_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int s = 0; s < PIPE_DEPTH; s++) begin
        st_rem_r[s] <= st_rem_nxt[s];
        st_div_r[s] <= st_div_nxt[s];
        st_idx_r[s] <= st_idx_nxt[s];
        st_cls_r[s] <= st_cls_nxt[s];
      end
    end
  end

  // final length select from the remainder
  assign off = st_rem_r[LAST][LEN_WIDTH-1:0];

  always_comb begin
    err_nxt = 1'b0;
    case (st_cls_r[LAST])
      CLS_FIXED:     len_nxt = cfg.fixed_length;
      CLS_INC:       len_nxt = cfg.min_length + off;
      CLS_DEC:       len_nxt = cfg.max_length - off;
      CLS_IMIX:      len_nxt = imix_len(off[IMIX_SEL_WIDTH-1:0]);
      CLS_RANGE_ERR: begin
        len_nxt = cfg.min_length;
        err_nxt = 1'b1;
      end
      default:       len_nxt = LEN_DEFAULT;
    endcase
  end

  // output register
  assign out_valid_nxt = pipe_en ? st_valid_r[LAST] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_len_r <= len_nxt;
      out_err_r <= err_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_length = out_len_r;
  assign out_range_error  = out_err_r;

endmodule

`default_nettype wire

>>> hdl/frame_length_by_mode.sv
`default_nettype none

// Frame length generator: takes one frame index per cycle while in_stall is low and
// answers the frame's length for the configured mode (fixed, increment, decrement,
// IMIX; other modes give 64). It sustains one word per clock while out_stall is low.
// When nothing stalls, an accepted index passes through the holding stage, the
// two-entry queue and the 31 stages of the remainder pipeline (one index bit each),
// after which the word sits in the output register. Registers must only be written
// while the block holds no word.
module frame_length_by_mode (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [flbm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [flbm_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [flbm_pkg::INDEX_WIDTH-1:0]    in_frame_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [flbm_pkg::LEN_WIDTH-1:0]           out_frame_length,
  output logic                                     out_range_error
);
  import flbm_pkg::*;

  `include "frame_length_by_mode_assert.svh"

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LENGTH_MODE:  cfg_nxt.length_mode  = cfg_wdata[MODE_WIDTH-1:0];
        CFG_FIXED_LENGTH: cfg_nxt.fixed_length = cfg_wdata[LEN_WIDTH-1:0];
        CFG_MIN_LENGTH:   cfg_nxt.min_length   = cfg_wdata[LEN_WIDTH-1:0];
        CFG_MAX_LENGTH:   cfg_nxt.max_length   = cfg_wdata[LEN_WIDTH-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_mode  <= RST_LENGTH_MODE;
      cfg_r.fixed_length <= RST_FIXED;
      cfg_r.min_length   <= RST_MIN;
      cfg_r.max_length   <= RST_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  flbm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_index (in_frame_index),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // queue between front and back
  flbm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back: remainder pipeline and length select
  flbm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_length (out_frame_length),
    .out_range_error  (out_range_error)
  );

  // checks
  `FLBM_ASSERT_NOW(a_err_len, out_valid && out_range_error, out_frame_length == cfg_r.min_length)
  `FLBM_ASSERT_NOW(a_err_mode, out_valid && out_range_error,
                   (cfg_r.length_mode == MODE_INC || cfg_r.length_mode == MODE_DEC) &&
                   (cfg_r.max_length < cfg_r.min_length))
  `FLBM_ASSERT_NOW(a_stall_cause, in_stall, push_valid && !push_ready)
  `FLBM_ASSERT_NEXT(a_queue_drains, pop_valid && pop_ready && !push_valid, push_ready)

endmodule

`default_nettype wire
